### rtl/core/etscr_pkg.sv
// shared types and constants for the edge-timed serial character receiver
package etscr_pkg;

  localparam int TsWidth   = 16;
  localparam int CharWidth = 7;
  localparam int GapWidth  = 4;

  // operation codes
  localparam logic OpEdge    = 1'b0;
  localparam logic OpRestart = 1'b1;

  localparam logic [3:0] IdleCount    = 4'd15;
  localparam logic [3:0] MaxGapBits   = 4'd12;
  localparam logic [3:0] FrameBits    = 4'd9;
  localparam logic [3:0] LastBitIndex = 4'd7;
  localparam logic [7:0] DataMask     = 8'h7F;
  localparam logic [7:0] StartMask    = 8'h01;

  typedef struct packed {
    logic               operation;
    logic [TsWidth-1:0] timestamp;
    logic               level_high;
  } edge_item_t;

  typedef struct packed {
    logic                 valid;
    logic [CharWidth-1:0] char_value;
    logic                 parity_bit;
  } char_result_t;

endpackage

### rtl/core/etscr_edge_if.sv
// handshake channel carrying line edge and restart beats
interface etscr_edge_if;
  import etscr_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [TsWidth-1:0] timestamp;
  logic               level_high;

  modport source (output valid, operation, timestamp, level_high, input ready);
  modport sink (input valid, operation, timestamp, level_high, output ready);
endinterface

### rtl/core/etscr_char_if.sv
// handshake channel carrying received characters
interface etscr_char_if;
  import etscr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] char_value;
  logic                 parity_bit;

  modport source (output valid, char_value, parity_bit, input ready);
  modport sink (input valid, char_value, parity_bit, output ready);
endinterface

### rtl/core/etscr_gap_quant.sv
// converts the wrapped timestamp gap into whole bit periods, saturated at 13
module etscr_gap_quant #(
  parameter int BIT_TICKS = 1536
) (
  input  logic [etscr_pkg::TsWidth-1:0]  now,
  input  logic [etscr_pkg::TsWidth-1:0]  last_ts,
  output logic [etscr_pkg::GapWidth-1:0] gap_bits
);
  import etscr_pkg::*;

  localparam int Steps = int'(MaxGapBits) + 1;

  logic [TsWidth-1:0] elapsed;
  logic [Steps:1]     reached;

  assign elapsed = now - last_ts;

  // thermometer of compares against multiples of the bit period
  for (genvar k = 1; k <= Steps; k++) begin : g_thr
    localparam logic [TsWidth:0] Thr = (TsWidth+1)'(k * BIT_TICKS);
    assign reached[k] = {1'b0, elapsed} >= Thr;
  end

  always_comb begin
    gap_bits = '0;
    for (int k = 1; k <= Steps; k++) begin
      if (reached[k]) begin
        gap_bits = GapWidth'(k);
      end
    end
  end

endmodule

### rtl/core/etscr_frame.sv
// frame state and bit assembly, one item per cycle while fire is high
module etscr_frame (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           fire,
  input  etscr_pkg::edge_item_t          item,
  input  logic [etscr_pkg::GapWidth-1:0] gap_bits,
  output logic [etscr_pkg::TsWidth-1:0]  last_ts,
  output etscr_pkg::char_result_t        result
);
  import etscr_pkg::*;

  logic [3:0]         bit_count, bit_count_next;
  logic [7:0]         fill_mask, fill_mask_next;
  logic [7:0]         assembled, assembled_next;
  logic [TsWidth-1:0] last_ts_next;

  logic [3:0] left;
  logic       overrun;
  logic [3:0] take;
  logic [3:0] cnt_sum;
  logic [7:0] fill;
  logic [7:0] low_mask;
  logic [7:0] val_new;

  assign left     = FrameBits - {1'b0, bit_count[2:0]};
  assign overrun  = gap_bits > left;
  assign take     = overrun ? left : gap_bits;
  assign cnt_sum  = {1'b0, bit_count[2:0]} + take;
  assign low_mask = 8'(16'(fill_mask) << (take - 4'd1));

  // positions filled by a run of mark bits
  always_comb begin
    fill = '0;
    for (int i = 0; i < int'(FrameBits); i++) begin
      if (4'(i) < take) begin
        fill = fill | 8'(16'(fill_mask) << i);
      end
    end
  end

  always_comb begin
    bit_count_next = bit_count;
    fill_mask_next = fill_mask;
    assembled_next = assembled;
    last_ts_next   = last_ts;
    val_new        = assembled;
    result         = '0;
    if (fire) begin
      last_ts_next = item.timestamp;
      if (item.operation == OpRestart) begin
        bit_count_next = IdleCount;
      end else if (bit_count > LastBitIndex) begin
        if (item.level_high) begin
          bit_count_next = '0;
          fill_mask_next = StartMask;
          assembled_next = '0;
        end
      end else if (gap_bits == '0) begin
        bit_count_next = bit_count;
      end else if (gap_bits > MaxGapBits) begin
        bit_count_next = IdleCount;
      end else begin
        if (item.level_high) begin
          val_new        = assembled | fill;
          fill_mask_next = 8'(16'(fill_mask) << (take + 4'd1));
        end else begin
          val_new        = assembled | low_mask;
          fill_mask_next = low_mask;
        end
        assembled_next = val_new;
        bit_count_next = cnt_sum;
        if (cnt_sum > LastBitIndex) begin
          result.valid      = 1'b1;
          result.char_value = CharWidth'(val_new & DataMask);
          result.parity_bit = val_new[7];
          if (item.level_high && overrun) begin
            bit_count_next = '0;
            fill_mask_next = StartMask;
            assembled_next = '0;
          end else begin
            bit_count_next = IdleCount;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count <= IdleCount;
      fill_mask <= '0;
      assembled <= '0;
      last_ts   <= '0;
    end else begin
      bit_count <= bit_count_next;
      fill_mask <= fill_mask_next;
      assembled <= assembled_next;
      last_ts   <= last_ts_next;
    end
  end

endmodule

### rtl/core/edge_timed_serial_char_receiver.sv
// Edge-timed receiver for 7E1 characters on an inverted serial line.
// edge_in takes one beat per line edge (operation edge) carrying the timer
// value at the edge and the new level, or a restart beat that returns the
// receiver to waiting for a start bit and resyncs its timestamp.
// char_out gives one beat per completed character: seven data bits, LSB
// first, and the parity bit as received, unchecked.
// Throughput is one edge_in beat per cycle while char_out is not stalled. A
// beat is held in an input register, then the frame logic updates its state
// and loads the output register, so a character reaches char_out through
// the input and output registers after the edge beat that completes it is
// taken. The gap in bit periods comes from a row of compares against
// multiples of BIT_TICKS, all combinational.
// Reset empties both registers and puts the receiver in the waiting state
// with a zero timestamp. When char_out is stalled, the output register holds
// its character; one more edge beat is taken into the input register, then
// edge_in.ready drops until the character is taken.
module edge_timed_serial_char_receiver #(
  parameter int BIT_TICKS = 1536
) (
  input logic         clk,
  input logic         rst,
  etscr_edge_if.sink  edge_in,
  etscr_char_if.source char_out
);
  import etscr_pkg::*;

  logic                  in_full;
  edge_item_t            in_item;
  logic                  out_full;
  logic [CharWidth-1:0]  out_char;
  logic                  out_parity;
  logic                  out_free;
  logic                  advance;
  logic [TsWidth-1:0]    last_ts;
  logic [GapWidth-1:0]   gap_bits;
  char_result_t          result;

  assign out_free      = !out_full || char_out.ready;
  assign advance       = in_full && out_free;
  assign edge_in.ready = !in_full || advance;

  assign char_out.valid      = out_full;
  assign char_out.char_value = out_char;
  assign char_out.parity_bit = out_parity;

  etscr_gap_quant #(
    .BIT_TICKS(BIT_TICKS)
  ) u_gap (
    .now      (in_item.timestamp),
    .last_ts  (last_ts),
    .gap_bits (gap_bits)
  );

  etscr_frame u_frame (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .item     (in_item),
    .gap_bits (gap_bits),
    .last_ts  (last_ts),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (edge_in.valid && edge_in.ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (edge_in.valid && edge_in.ready) begin
      in_item.operation  <= edge_in.operation;
      in_item.timestamp  <= edge_in.timestamp;
      in_item.level_high <= edge_in.level_high;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_free) begin
      out_full <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && result.valid) begin
      out_char   <= result.char_value;
      out_parity <= result.parity_bit;
    end
  end

endmodule

### tb/tb.sv
// self-checking testbench for the edge-timed serial character receiver
module tb;
  import etscr_pkg::*;

  localparam int BitTicks   = 1536;
  localparam int StallLimit = 2000;
  localparam int ItemTarget = 1250;

  logic clk = 1'b0;
  logic rst = 1'b1;

  etscr_edge_if edge_bus ();
  etscr_char_if char_bus ();

  edge_timed_serial_char_receiver #(
    .BIT_TICKS(BitTicks)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .edge_in(edge_bus),
    .char_out(char_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver state as the block should hold it
  logic [3:0]  rx_count;
  logic [7:0]  rx_mask;
  logic [7:0]  rx_acc;
  logic [15:0] rx_last_ts;

  char_result_t expected_chars[$];
  char_result_t head_char;

  // line generator state
  logic [15:0] gen_ts;
  int          pend_bits;
  logic        line_hi;
  logic        calm;

  int edges_sent;
  int restarts_sent;
  int chars_checked;
  int errors;
  int idle_cycles;

  function automatic char_result_t decode_edge(input edge_item_t item);
    char_result_t res;
    logic [15:0]  span;
    int unsigned  nbits;
    int unsigned  room;
    int unsigned  taken;
    int unsigned  i;
    logic         spill;
    res = '0;
    if (item.operation == OpRestart) begin
      rx_count = IdleCount;
      rx_last_ts = item.timestamp;
      return res;
    end
    span = item.timestamp - rx_last_ts;
    nbits = span / BitTicks;
    rx_last_ts = item.timestamp;
    if (rx_count > LastBitIndex) begin
      if (item.level_high) begin
        rx_count = 4'd0;
        rx_mask = StartMask;
        rx_acc = 8'h00;
      end
      return res;
    end
    if (nbits == 0) return res;
    if (nbits > MaxGapBits) begin
      rx_count = IdleCount;
      return res;
    end
    room = FrameBits - rx_count;
    spill = nbits > room;
    taken = spill ? room : nbits;
    rx_count = rx_count + 4'(taken);
    if (item.level_high) begin
      // mark bits run up to this edge, the space bit starting here is skipped
      for (i = 0; i < taken; i++) begin
        rx_acc = rx_acc | rx_mask;
        rx_mask = rx_mask << 1;
      end
      rx_mask = rx_mask << 1;
    end else begin
      rx_mask = rx_mask << (taken - 1);
      rx_acc = rx_acc | rx_mask;
    end
    if (rx_count > LastBitIndex) begin
      res.valid = 1'b1;
      res.char_value = CharWidth'(rx_acc & DataMask);
      res.parity_bit = rx_acc[7];
      if (!item.level_high || !spill) begin
        rx_count = IdleCount;
      end else begin
        // a late rising edge is the start bit of the next character
        rx_count = 4'd0;
        rx_mask = StartMask;
        rx_acc = 8'h00;
      end
    end
    return res;
  endfunction

  task automatic send_edge(input logic op, input logic [15:0] ts, input logic lvl);
    edge_item_t   item;
    char_result_t res;
    item.operation = op;
    item.timestamp = ts;
    item.level_high = lvl;
    if (!calm) begin
      while ($urandom_range(99) < 11) begin
        edge_bus.valid <= 1'b0;
        @(posedge clk);
      end
    end
    edge_bus.valid <= 1'b1;
    edge_bus.operation <= op;
    edge_bus.timestamp <= ts;
    edge_bus.level_high <= lvl;
    @(posedge clk);
    while (!edge_bus.ready) @(posedge clk);
    res = decode_edge(item);
    if (res.valid) expected_chars.push_back(res);
    if (op == OpRestart) restarts_sent++;
    else edges_sent++;
  endtask

  task automatic line_edge(input int gap, input int jit, input logic lvl);
    logic [15:0] ts;
    ts = gen_ts + 16'(gap * BitTicks + jit);
    send_edge(OpEdge, ts, lvl);
    gen_ts = ts;
    line_hi = lvl;
    pend_bits = 0;
  endtask

  task automatic restart_at(input logic [15:0] ts, input logic lvl);
    send_edge(OpRestart, ts, lvl);
    gen_ts = ts;
    pend_bits = 0;
  endtask

  // start bit, seven data bits and parity, then stop bits; high is a space
  task automatic send_char(input logic [7:0] ch, input int stop_bits, input int idle_bits,
                           input int max_edges);
    int   pos;
    int   sent;
    logic want;
    sent = 0;
    if (line_hi) begin
      line_edge(pend_bits + 1, $urandom_range(BitTicks / 4), 1'b0);
      pend_bits = 1;
    end
    pend_bits += idle_bits;
    for (pos = 0; pos < 10 && sent < max_edges; pos++) begin
      want = (pos == 0) ? 1'b1 : (pos == 9) ? 1'b0 : !ch[pos-1];
      if (want != line_hi) begin
        line_edge(pend_bits, $urandom_range(BitTicks / 4), want);
        sent++;
      end
      pend_bits++;
    end
    pend_bits += stop_bits - 1;
  endtask

  task automatic test_restart();
    restart_at(16'hFFFF, 1'b1);
    restart_at(16'h0000, 1'b0);
  endtask

  task automatic test_idle_edges();
    line_edge(3, 0, 1'b0);
    send_char(8'h00, 1, 2, 99);
  endtask

  task automatic test_late_start();
    // trailing mark bits are closed by the next start bit
    send_char(8'hFF, 1, 1, 99);
    send_char(8'h60, 1, 0, 99);
  endtask

  task automatic test_glitch_and_abort();
    line_edge(2, 0, 1'b1);
    line_edge(0, 700, 1'b0);
    line_edge(13, 0, 1'b1);
    line_edge(1, 0, 1'b0);
  endtask

  task automatic test_falling_overrun();
    line_edge(2, 0, 1'b1);
    line_edge(1, 0, 1'b0);
    line_edge(11, 5, 1'b0);
  endtask

  task automatic test_full_gap();
    line_edge(3, 0, 1'b1);
    line_edge(12, BitTicks - 1, 1'b1);
    restart_at(gen_ts + 16'd100, 1'b0);
    line_edge(1, 0, 1'b0);
  endtask

  task automatic test_wrap();
    restart_at(16'hFF00, 1'b1);
    line_edge(0, 200, 1'b1);
    line_edge(9, 0, 1'b0);
  endtask

  task automatic test_calm_burst();
    int n;
    calm = 1'b1;
    for (n = 0; n < 20; n++) send_char(8'($urandom_range(255)), 1, 0, 99);
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    int pick;
    while (edges_sent + restarts_sent < ItemTarget) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_char(8'($urandom_range(255)), $urandom_range(1, 3),
                  ($urandom_range(9) == 0) ? $urandom_range(3, 12) : $urandom_range(2), 99);
      end else if (pick < 78) begin
        line_edge($urandom_range(14), $urandom_range(BitTicks - 1), 1'($urandom_range(1)));
      end else if (pick < 83) begin
        restart_at(16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)));
      end else if (pick < 88) begin
        line_edge(0, $urandom_range(BitTicks - 1), !line_hi);
      end else if (pick < 93) begin
        line_edge($urandom_range(13, 40), $urandom_range(BitTicks - 1), 1'($urandom_range(1)));
      end else begin
        // character cut off partway
        send_char(8'($urandom_range(255)), 1, $urandom_range(2), $urandom_range(1, 4));
      end
    end
  endtask

  always @(posedge clk) char_bus.ready <= calm || ($urandom_range(99) >= 11);

  always @(posedge clk) begin
    if (!rst && char_bus.valid && char_bus.ready) begin
      chars_checked++;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected char expected none actual %h parity %b", $time,
                 char_bus.char_value, char_bus.parity_bit);
        errors++;
      end else begin
        head_char = expected_chars.pop_front();
        if (char_bus.char_value !== head_char.char_value) begin
          $display("%0t: char_value expected %h actual %h", $time, head_char.char_value,
                   char_bus.char_value);
          errors++;
        end
        if (char_bus.parity_bit !== head_char.parity_bit) begin
          $display("%0t: parity_bit expected %b actual %b", $time, head_char.parity_bit,
                   char_bus.parity_bit);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (edge_bus.valid && edge_bus.ready) || (char_bus.valid && char_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no beat moved for %0d cycles", $time, StallLimit);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rx_count = IdleCount;
    rx_mask = 8'h00;
    rx_acc = 8'h00;
    rx_last_ts = 16'h0000;
    gen_ts = 16'h0000;
    pend_bits = 0;
    line_hi = 1'b0;
    calm = 1'b0;
    edges_sent = 0;
    restarts_sent = 0;
    chars_checked = 0;
    errors = 0;
    edge_bus.valid <= 1'b0;
    edge_bus.operation <= OpEdge;
    edge_bus.timestamp <= '0;
    edge_bus.level_high <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_restart();
    test_idle_edges();
    test_late_start();
    test_glitch_and_abort();
    test_falling_overrun();
    test_full_gap();
    test_wrap();
    test_calm_burst();
    test_random_traffic();

    edge_bus.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("tb: %0d line edges and %0d restarts sent, %0d characters checked",
             edges_sent, restarts_sent, chars_checked);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
